// ===== hw/rtl/mdlc_pkg.sv =====
// ----------------------------------------------------------------------------
// mdlc_pkg: shared types and constants of the motion door LED controller
// Phase encodings, register indexes and reset values, beat kinds and the result beat.
// ----------------------------------------------------------------------------
package mdlc_pkg;

  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MOTION_DELAY = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DOOR_HOLD    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LED_PERIOD   = 2'd2;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] MOTION_DELAY_RST = 16'd50;
  localparam logic [CFG_WIDTH-1:0] DOOR_HOLD_RST    = 16'd10000;
  localparam logic [CFG_WIDTH-1:0] LED_PERIOD_RST   = 16'd500;

  // Beat kinds carried on the input tuser
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    MP_IDLE     = 2'd0,
    MP_WAIT_ON  = 2'd1,
    MP_ACTIVE   = 2'd2,
    MP_WAIT_OFF = 2'd3
  } motion_phase_e;

  typedef enum logic [1:0] {
    DP_CLOSED     = 2'd0,
    DP_OPEN       = 2'd1,
    DP_WAIT_CLOSE = 2'd2
  } door_phase_e;

  // One result beat
  typedef struct packed {
    logic led_drive;
    logic door_drive;
    logic motion_seen;
  } result_t;

endpackage

// ===== hw/rtl/motion_door_led_controller_top.sv =====
// ----------------------------------------------------------------------------
// motion_door_led_controller_top: motion qualified door and LED controller
// Tick and update beats drive a motion qualifier, a door machine and a
// blinking LED machine; every input beat yields one status beat.
// ----------------------------------------------------------------------------
// Each input beat is a timer tick (tuser = 0) or an update step (tuser = 1)
// carrying the raw active-low sensor level in tdata bit 0. A tick counts the
// three timers down by one, stopping at zero, and reports the current status.
// An update runs the motion qualifier, then the door machine, then the LED
// machine, all in the same cycle, and reports the new status. Every input
// beat produces exactly one output beat. The block takes one beat per clock
// while the sink takes its beats: state updates are combinational between the
// state and result registers, and the result register frees up whenever the
// sink takes its beat, so the streams run back to back at one beat per cycle.
// The user must write registers through cfg_we_i / cfg_idx_i / cfg_wdata_i
// only while the block is idle, which the block does not enforce; index 3 is
// ignored. Values over the TIMER_WIDTH-bit maximum load the timers saturated.
module motion_door_led_controller_top
  import mdlc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  // Configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]     cfg_wdata_i,

  // Input stream
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [7:0]               s_axis_tdata_i,   // [0] sensor_pin, [7:1] zero
  input  logic                     s_axis_tuser_i,   // [0] kind

  // Output stream
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [7:0]               m_axis_tdata_o    // [0] motion_seen,
                                                     // [1] door_drive,
                                                     // [2] led_drive, [7:3] zero
);

  localparam int unsigned WIDE_W = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [TIMER_WIDTH-1:0] TIMER_ZERO = '0;

  // Configuration registers
  logic [CFG_WIDTH-1:0] motion_delay_q, door_hold_q, led_period_q;

  // Machine state
  motion_phase_e        motion_phase_q, motion_phase_d;
  door_phase_e          door_phase_q, door_phase_d;
  logic                 led_lit_q, led_lit_d;
  logic [TIMER_WIDTH-1:0] motion_timer_q, motion_timer_d;
  logic [TIMER_WIDTH-1:0] door_timer_q, door_timer_d;
  logic [TIMER_WIDTH-1:0] led_timer_q, led_timer_d;

  // Result register
  logic    out_valid_q;
  result_t result_q, result_d;

  logic accept;
  logic motion;
  logic flag_now, flag_d;
  logic [TIMER_WIDTH-1:0] motion_load, door_load, led_load;

  // Saturate a register value into the timer width
  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [CFG_WIDTH-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(v);
    if (wide > WIDE_W'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_WIDTH'(wide);
  endfunction

  assign motion_load = sat_load(motion_delay_q);
  assign door_load   = sat_load(door_hold_q);
  assign led_load    = sat_load(led_period_q);

  // Take a new beat whenever the result slot is empty or drains this cycle
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign motion = !s_axis_tdata_i[0];

  assign flag_now = (motion_phase_q == MP_ACTIVE) || (motion_phase_q == MP_WAIT_OFF);

  // Motion qualifier next state
  always_comb begin
    motion_phase_d = motion_phase_q;
    motion_timer_d = motion_timer_q;
    if (s_axis_tuser_i == KIND_UPDATE) begin
      case (motion_phase_q)
        MP_IDLE: begin
          if (motion) begin
            motion_timer_d = motion_load;
            motion_phase_d = MP_WAIT_ON;
          end
        end
        MP_WAIT_ON: begin
          if (!motion) begin
            motion_phase_d = MP_IDLE;
          end else if (motion_timer_q == TIMER_ZERO) begin
            motion_phase_d = MP_ACTIVE;
          end
        end
        MP_ACTIVE: begin
          if (!motion) begin
            motion_phase_d = MP_WAIT_OFF;
            motion_timer_d = motion_load;
          end
        end
        default: begin
          if (motion) begin
            motion_phase_d = MP_ACTIVE;
          end else if (motion_timer_q == TIMER_ZERO) begin
            motion_phase_d = MP_IDLE;
          end
        end
      endcase
    end else if (motion_timer_q != TIMER_ZERO) begin
      motion_timer_d = motion_timer_q - 1'b1;
    end
  end

  assign flag_d = (motion_phase_d == MP_ACTIVE) || (motion_phase_d == MP_WAIT_OFF);

  // Door machine next state, fed by the freshly qualified flag
  always_comb begin
    door_phase_d = door_phase_q;
    door_timer_d = door_timer_q;
    if (s_axis_tuser_i == KIND_UPDATE) begin
      case (door_phase_q)
        DP_OPEN: begin
          if (!flag_d) begin
            door_timer_d = door_load;
            door_phase_d = DP_WAIT_CLOSE;
          end
        end
        DP_WAIT_CLOSE: begin
          if (flag_d) begin
            door_phase_d = DP_OPEN;
          end else if (door_timer_q == TIMER_ZERO) begin
            door_phase_d = DP_CLOSED;
          end
        end
        default: begin
          door_phase_d = flag_d ? DP_OPEN : DP_CLOSED;
        end
      endcase
    end else if (door_timer_q != TIMER_ZERO) begin
      door_timer_d = door_timer_q - 1'b1;
    end
  end

  // LED blinker next state; once lit it always finishes its on phase
  always_comb begin
    led_lit_d   = led_lit_q;
    led_timer_d = led_timer_q;
    if (s_axis_tuser_i == KIND_UPDATE) begin
      if (!led_lit_q) begin
        if (flag_d && (led_timer_q == TIMER_ZERO)) begin
          led_lit_d   = 1'b1;
          led_timer_d = led_load;
        end
      end else if (led_timer_q == TIMER_ZERO) begin
        led_lit_d   = 1'b0;
        led_timer_d = led_load;
      end
    end else if (led_timer_q != TIMER_ZERO) begin
      led_timer_d = led_timer_q - 1'b1;
    end
  end

  // Status for this beat: a tick reports the state as it stands
  always_comb begin
    if (s_axis_tuser_i == KIND_UPDATE) begin
      result_d.motion_seen = flag_d;
      result_d.door_drive  = (door_phase_d == DP_OPEN) || (door_phase_d == DP_WAIT_CLOSE);
      result_d.led_drive   = led_lit_d;
    end else begin
      result_d.motion_seen = flag_now;
      result_d.door_drive  = (door_phase_q == DP_OPEN) || (door_phase_q == DP_WAIT_CLOSE);
      result_d.led_drive   = led_lit_q;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_delay_q <= MOTION_DELAY_RST;
      door_hold_q    <= DOOR_HOLD_RST;
      led_period_q   <= LED_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOTION_DELAY: motion_delay_q <= cfg_wdata_i;
        REG_DOOR_HOLD:    door_hold_q    <= cfg_wdata_i;
        REG_LED_PERIOD:   led_period_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Machine state: advance only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_phase_q <= MP_IDLE;
      door_phase_q   <= DP_CLOSED;
      led_lit_q      <= 1'b0;
      motion_timer_q <= '0;
      door_timer_q   <= '0;
      led_timer_q    <= '0;
    end else if (accept) begin
      motion_phase_q <= motion_phase_d;
      door_phase_q   <= door_phase_d;
      led_lit_q      <= led_lit_d;
      motion_timer_q <= motion_timer_d;
      door_timer_q   <= door_timer_d;
      led_timer_q    <= led_timer_d;
    end
  end

  // Result slot: load on accept, drop once the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, result_q};

endmodule
